>>> sv/stm_pkg.sv
// Shared types, constants and the quarter-wave sine table for the sweep tone mixer.
// No dependencies.
package stm_pkg;

  localparam int unsigned VOICES_DEF   = 4;
  localparam int unsigned RATE_HZ_DEF  = 22050;
  localparam int unsigned SINE_ENTRIES = 256;
  localparam int unsigned SINE_AW      = $clog2(SINE_ENTRIES);
  localparam int unsigned RATE_W       = 17;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [15:0] LFSR_SEED   = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS   = 16'hB400;
  localparam logic signed [15:0] FULL_Q15 = 16'sd32767;

  // Request kinds (tuser)
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;

  // Waveforms
  localparam logic [1:0] WAVE_SQR = 2'd0;
  localparam logic [1:0] WAVE_TRI = 2'd1;
  localparam logic [1:0] WAVE_RND = 2'd2;
  localparam logic [1:0] WAVE_SIN = 2'd3;

  typedef logic [15:0] sine_rom_t [SINE_ENTRIES+1];

  // Taylor series of sin(x), x in Q30 over [0, pi/2], result Q15
  function automatic logic [15:0] series_sine(logic [63:0] x);
    logic [63:0] x2, term, plus, minus, s, v;
    x2 = (x * x) >> 30;
    term = x;
    plus = x;
    minus = 64'd0;
    term = ((term * x2) >> 30) / 64'd6;   minus = minus + term;
    term = ((term * x2) >> 30) / 64'd20;  plus  = plus + term;
    term = ((term * x2) >> 30) / 64'd42;  minus = minus + term;
    term = ((term * x2) >> 30) / 64'd72;  plus  = plus + term;
    term = ((term * x2) >> 30) / 64'd110; minus = minus + term;
    term = ((term * x2) >> 30) / 64'd156; plus  = plus + term;
    term = ((term * x2) >> 30) / 64'd210; minus = minus + term;
    s = (plus > minus) ? plus - minus : 64'd0;
    v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    return (v > 64'd32767) ? 16'd32767 : v[15:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t r;
    for (int k = 0; k <= SINE_ENTRIES; k++) begin
      r[k] = series_sine((HALF_PI_Q30 * 64'(k)) / SINE_ENTRIES);
    end
    return r;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

>>> sv/stm_serial_div.sv
// Bit-serial restoring divider: quotient of (num << 16 or num << 32) / den, low 32 bits.
// Uses stm_pkg.
module stm_serial_div import stm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              wide_i,   // 1: num << 32, else num << 16
  input  logic [15:0]       num_i,
  input  logic [RATE_W-1:0] den_i,
  output logic              done_o,
  output logic [31:0]       quo_o
);

  logic              busy_q;
  logic              done_q;
  logic [5:0]        cnt_q;
  logic [47:0]       dvd_q;
  logic [RATE_W-1:0] rem_q;
  logic [RATE_W-1:0] den_q;
  logic [31:0]       quo_q;
  logic [RATE_W:0]   rem_try;
  logic              ge;
  logic [RATE_W:0]   rem_sub;

  // one quotient bit per cycle
  assign rem_try = {rem_q, dvd_q[47]};
  assign ge      = rem_try >= {1'b0, den_q};
  assign rem_sub = rem_try - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= wide_i ? 6'd48 : 6'd32;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {num_i, 32'd0};
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[46:0], 1'b0};
      rem_q <= ge ? rem_sub[RATE_W-1:0] : rem_try[RATE_W-1:0];
      quo_q <= {quo_q[30:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> sv/stm_wave_gen.sv
// Waveform sample from phase: square, triangle, noise LFSR step and quarter-wave sine.
// Uses stm_pkg (sine table, LFSR taps).
module stm_wave_gen import stm_pkg::*; (
  input  logic [1:0]         wave_i,
  input  logic [31:0]        phase_i,
  input  logic [15:0]        lfsr_i,
  output logic signed [15:0] sample_o,
  output logic [15:0]        lfsr_o
);

  logic [16:0]        u;
  logic [16:0]        d;
  logic signed [18:0] tri_s;
  logic signed [17:0] nz_s;
  logic [SINE_AW:0]   idx;
  logic [SINE_AW:0]   ridx;
  logic [15:0]        rom_v;

  // Galois LFSR step
  assign lfsr_o = lfsr_i[0] ? ({1'b0, lfsr_i[15:1]} ^ LFSR_TAPS) : {1'b0, lfsr_i[15:1]};

  assign u     = {1'b0, phase_i[31:16]};
  assign d     = phase_i[31] ? (17'd65536 - u) : u;
  assign tri_s = $signed({1'b0, d, 1'b0}) - 19'sd32768;
  assign nz_s  = $signed({2'b0, lfsr_o}) - 18'sd32768;

  // sine quadrant folding
  assign idx   = {1'b0, phase_i[29 -: SINE_AW]};
  assign ridx  = phase_i[30] ? ((SINE_AW+1)'(SINE_ENTRIES) - idx) : idx;
  assign rom_v = SINE_ROM[ridx];

  always_comb begin
    unique case (wave_i)
      WAVE_SQR: sample_o = phase_i[31] ? -FULL_Q15 : FULL_Q15;
      WAVE_TRI: begin
        if (tri_s > 19'sd32767)       sample_o = FULL_Q15;
        else if (tri_s < -19'sd32767) sample_o = -FULL_Q15;
        else                          sample_o = tri_s[15:0];
      end
      WAVE_RND: sample_o = (nz_s < -18'sd32767) ? -FULL_Q15 : nz_s[15:0];
      default: sample_o = phase_i[31] ? -$signed(rom_v) : $signed(rom_v);
    endcase
  end

endmodule

>>> sv/sweep_tone_mixer.sv
// Sweep tone mixer top: voice store, per-voice sequencer, mixer and output register.
// Tick: each active voice runs bit-serial divisions of 32 and 48 steps and multiply steps,
// each idle voice only its check and next states, then the finish state clamps the mix.
// Start and stop stay in idle; one request at a time, next accepted once the result appears.
// Reset (rst_ni low, async): all voices idle and cleared, LFSR = 0xACE1, no output.
// Uses stm_pkg, stm_serial_div, stm_wave_gen.
module sweep_tone_mixer import stm_pkg::*; #(
  parameter int unsigned VOICES  = VOICES_DEF,
  parameter int unsigned RATE_HZ = RATE_HZ_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // wave[1:0], start_hz[15:2], end_hz[29:16],
                                     // length_samples[45:30], gain[54:46]
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // pcm[15:0], busy_mask[19:16]
);

  localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned MW = (VOICES < 4) ? VOICES : 4;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CHK   = 4'd1;
  localparam logic [3:0] ST_DIVT  = 4'd2;
  localparam logic [3:0] ST_FRQ1  = 4'd3;
  localparam logic [3:0] ST_FRQ2  = 4'd4;
  localparam logic [3:0] ST_FSUM  = 4'd5;
  localparam logic [3:0] ST_DIVI  = 4'd6;
  localparam logic [3:0] ST_SAMP  = 4'd7;
  localparam logic [3:0] ST_MUL1  = 4'd8;
  localparam logic [3:0] ST_MUL2  = 4'd9;
  localparam logic [3:0] ST_ACC   = 4'd10;
  localparam logic [3:0] ST_NEXT  = 4'd11;
  localparam logic [3:0] ST_FIN   = 4'd12;

  localparam logic signed [47:0] LIMIT = 48'sd32767 <<< 24;

  // voice store
  logic [VOICES-1:0] on_q;
  logic [1:0]        wave_q   [VOICES];
  logic [13:0]       start_q  [VOICES];
  logic [13:0]       end_q    [VOICES];
  logic [15:0]       len_q    [VOICES];
  logic [15:0]       el_q     [VOICES];
  logic [8:0]        gain_q   [VOICES];
  logic [31:0]       phase_q  [VOICES];
  logic [15:0]       lfsr_q;

  logic [3:0]        state_q;
  logic [VW-1:0]     vidx_q;
  logic [15:0]       t16_q;
  logic [30:0]       p1_q;
  logic [29:0]       p2_q;
  logic signed [15:0] samp_q;
  logic signed [25:0] sg_q;
  logic signed [43:0] prod_q;
  logic signed [47:0] mix_q;
  logic              out_valid_q;
  logic [15:0]       pcm_q;
  logic [3:0]        mask_q;

  logic [1:0]        in_kind;
  logic [1:0]        in_wave;
  logic [13:0]       in_start;
  logic [13:0]       in_end;
  logic [15:0]       in_len;
  logic [8:0]        in_gain;
  logic              accept;
  logic              free_found;
  logic [VW-1:0]     free_idx;
  logic [16:0]       om;
  logic [31:0]       fsum;
  logic              div_start;
  logic              div_wide;
  logic [15:0]       div_num;
  logic              div_done;
  logic [31:0]       div_quo;
  logic signed [15:0] wg_sample;
  logic [15:0]       wg_lfsr;
  logic [47:0]       mag;
  logic [15:0]       pcm_d;
  logic [3:0]        mask_d;

  assign in_kind  = s_axis_tuser;
  assign in_wave  = s_axis_tdata[1:0];
  assign in_start = s_axis_tdata[15:2];
  assign in_end   = s_axis_tdata[29:16];
  assign in_len   = s_axis_tdata[45:30];
  assign in_gain  = s_axis_tdata[54:46];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // lowest idle voice
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int v = VOICES - 1; v >= 0; v--) begin
      if (!on_q[v]) begin
        free_found = 1'b1;
        free_idx   = VW'(v);
      end
    end
  end

  assign om   = 17'd65536 - {1'b0, t16_q};
  assign fsum = {1'b0, p1_q} + {2'b0, p2_q};

  // divider requests: progress in CHK, phase step in FSUM
  assign div_start = ((state_q == ST_CHK) && on_q[vidx_q] && (el_q[vidx_q] < len_q[vidx_q]))
                     || (state_q == ST_FSUM);
  assign div_wide  = (state_q == ST_FSUM);
  assign div_num   = (state_q == ST_FSUM) ? fsum[31:16] : el_q[vidx_q];

  stm_serial_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .wide_i  (div_wide),
    .num_i   (div_num),
    .den_i   ((state_q == ST_FSUM) ? RATE_W'(RATE_HZ) : {1'b0, len_q[vidx_q]}),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  stm_wave_gen u_wave (
    .wave_i   (wave_q[vidx_q]),
    .phase_i  (phase_q[vidx_q]),
    .lfsr_i   (lfsr_q),
    .sample_o (wg_sample),
    .lfsr_o   (wg_lfsr)
  );

  // clamp and truncate toward zero
  assign mag = 48'(-mix_q) >> 24;
  always_comb begin
    if (mix_q > LIMIT)       pcm_d = 16'(FULL_Q15);
    else if (mix_q < -LIMIT) pcm_d = 16'(-FULL_Q15);
    else if (!mix_q[47])     pcm_d = 16'(mix_q >>> 24);
    else                     pcm_d = 16'(-mag);
    mask_d = '0;
    for (int v = 0; v < MW; v++) mask_d[v] = on_q[v];
  end

  // sequencer and voice control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vidx_q      <= '0;
      on_q        <= '0;
      lfsr_q      <= LFSR_SEED;
      for (int v = 0; v < VOICES; v++) begin
        wave_q[v]  <= '0;
        start_q[v] <= '0;
        end_q[v]   <= '0;
        len_q[v]   <= '0;
        el_q[v]    <= '0;
        gain_q[v]  <= '0;
        phase_q[v] <= '0;
      end
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_kind)
              KIND_START: begin
                if (free_found) begin
                  on_q[free_idx]    <= 1'b1;
                  wave_q[free_idx]  <= in_wave;
                  start_q[free_idx] <= in_start;
                  end_q[free_idx]   <= in_end;
                  len_q[free_idx]   <= in_len;
                  el_q[free_idx]    <= '0;
                  gain_q[free_idx]  <= in_gain;
                  phase_q[free_idx] <= '0;
                end
              end
              KIND_STOP: on_q <= '0;
              KIND_TICK: begin
                vidx_q  <= '0;
                state_q <= ST_CHK;
              end
              default: ;
            endcase
          end
        end
        ST_CHK: begin
          if (!on_q[vidx_q]) begin
            state_q <= ST_NEXT;
          end else if (el_q[vidx_q] >= len_q[vidx_q]) begin
            on_q[vidx_q] <= 1'b0;
            state_q      <= ST_NEXT;
          end else begin
            state_q <= ST_DIVT;
          end
        end
        ST_DIVT: if (div_done) state_q <= ST_FRQ1;
        ST_FRQ1: state_q <= ST_FRQ2;
        ST_FRQ2: state_q <= ST_FSUM;
        ST_FSUM: state_q <= ST_DIVI;
        ST_DIVI: begin
          if (div_done) begin
            phase_q[vidx_q] <= phase_q[vidx_q] + div_quo;
            state_q         <= ST_SAMP;
          end
        end
        ST_SAMP: begin
          if (wave_q[vidx_q] == WAVE_RND) lfsr_q <= wg_lfsr;
          state_q <= ST_MUL1;
        end
        ST_MUL1: state_q <= ST_MUL2;
        ST_MUL2: state_q <= ST_ACC;
        ST_ACC: begin
          el_q[vidx_q] <= el_q[vidx_q] + 16'd1;
          state_q      <= ST_NEXT;
        end
        ST_NEXT: begin
          if (vidx_q == VW'(VOICES - 1)) begin
            state_q <= ST_FIN;
          end else begin
            vidx_q  <= vidx_q + VW'(1);
            state_q <= ST_CHK;
          end
        end
        ST_FIN: begin
          if (!out_valid_q || m_axis_tready) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // output valid: set on finish, cleared when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_FIN) && (!out_valid_q || m_axis_tready)) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tvalid && m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept && (in_kind == KIND_TICK)) mix_q <= '0;
    if ((state_q == ST_DIVT) && div_done) t16_q <= div_quo[15:0];
    if (state_q == ST_FRQ1) p1_q <= 31'(start_q[vidx_q] * om);
    if (state_q == ST_FRQ2) p2_q <= 30'(end_q[vidx_q] * t16_q);
    if (state_q == ST_SAMP) samp_q <= wg_sample;
    if (state_q == ST_MUL1) sg_q <= 26'(samp_q * $signed({1'b0, gain_q[vidx_q]}));
    if (state_q == ST_MUL2) prod_q <= 44'(sg_q * $signed({1'b0, om}));
    if (state_q == ST_ACC) mix_q <= mix_q + 48'(prod_q);
    if ((state_q == ST_FIN) && (!out_valid_q || m_axis_tready)) begin
      pcm_q  <= pcm_d;
      mask_q <= mask_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, mask_q, pcm_q};

`ifndef SYNTHESIS
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_FIN))
    else $error("result raised outside finish step");
  a_vidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (vidx_q <= VW'(VOICES - 1)))
    else $error("voice index out of range");
  a_div_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> ((state_q == ST_DIVT) || (state_q == ST_DIVI)))
    else $error("divider finished while not awaited");
`endif

endmodule

>>> bench/tb.sv
// Self-checking bench for the four-voice sweep tone mixer: start, stop and tick requests
// in, mixed PCM samples out, checked against a bit-exact predictor. Needs stm_pkg.
`timescale 1ns / 100ps

module tb import stm_pkg::*;;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned NUM_VOICES = 4;
  localparam int unsigned HOLD_LIMIT = 20000;
  localparam int unsigned NUM_RANDOM = 1680;

  // Voice state mirror, tone prediction and the queue of expected samples
  class tone_board;
    bit        on[NUM_VOICES];
    bit [1:0]  wave[NUM_VOICES];
    bit [13:0] f_start[NUM_VOICES];
    bit [13:0] f_end[NUM_VOICES];
    bit [15:0] len[NUM_VOICES];
    bit [15:0] elapsed[NUM_VOICES];
    bit [8:0]  gain[NUM_VOICES];
    bit [31:0] phase[NUM_VOICES];
    bit [15:0] lfsr;
    bit [19:0] samples_due[$];
    int        mismatches;

    function new();
      for (int v = 0; v < NUM_VOICES; v++) begin
        on[v] = 0; wave[v] = 0; f_start[v] = 0; f_end[v] = 0;
        len[v] = 0; elapsed[v] = 0; gain[v] = 0; phase[v] = 0;
      end
      lfsr = LFSR_SEED;
      mismatches = 0;
    endfunction

    function int wave_value(int v);
      bit [31:0] ph;
      int s, d, u, idx, e;
      ph = phase[v];
      case (wave[v])
        WAVE_SQR: return ph[31] ? -32767 : 32767;
        WAVE_TRI: begin
          u = ph[31:16];
          d = (u < 32768) ? u : 65536 - u;
          s = 2 * d - 32768;
          if (s > 32767) s = 32767;
          if (s < -32767) s = -32767;
          return s;
        end
        WAVE_RND: begin
          if (lfsr[0]) lfsr = (lfsr >> 1) ^ LFSR_TAPS;
          else lfsr = lfsr >> 1;
          s = int'(lfsr) - 32768;
          return (s < -32767) ? -32767 : s;
        end
        default: begin
          idx = ph[29:22];
          e = ph[30] ? SINE_ROM[SINE_ENTRIES - idx] : SINE_ROM[idx];
          return ph[31] ? -e : e;
        end
      endcase
    endfunction

    // Apply one accepted request; a tick queues one sample
    function void note_request(bit [1:0] kind, bit [55:0] data);
      longint mix, pcm;
      bit [63:0] t16, freq, incr;
      bit [3:0] mask;
      int s;
      case (kind)
        KIND_START: begin
          for (int v = 0; v < NUM_VOICES; v++) begin
            if (!on[v]) begin
              on[v] = 1; wave[v] = data[1:0]; f_start[v] = data[15:2];
              f_end[v] = data[29:16]; len[v] = data[45:30]; gain[v] = data[54:46];
              elapsed[v] = 0; phase[v] = 0;
              break;
            end
          end
        end
        KIND_STOP: for (int v = 0; v < NUM_VOICES; v++) on[v] = 0;
        KIND_TICK: begin
          mix = 0;
          for (int v = 0; v < NUM_VOICES; v++) begin
            if (!on[v]) continue;
            if (elapsed[v] >= len[v]) begin
              on[v] = 0;
              continue;
            end
            t16 = (64'(elapsed[v]) << 16) / 64'(len[v]);
            freq = (64'(f_start[v]) * (64'd65536 - t16) + 64'(f_end[v]) * t16) >> 16;
            incr = (freq << 32) / 64'd22050;
            phase[v] = phase[v] + incr[31:0];
            s = wave_value(v);
            mix += longint'(s) * longint'(gain[v]) * longint'(65536 - t16);
            elapsed[v] = elapsed[v] + 16'd1;
          end
          if (mix > (longint'(32767) << 24)) pcm = 32767;
          else if (mix < -(longint'(32767) << 24)) pcm = -32767;
          else pcm = mix / (longint'(1) << 24);
          for (int v = 0; v < NUM_VOICES; v++) mask[v] = on[v];
          samples_due.push_back({mask, 16'(pcm)});
        end
        default: ;
      endcase
    endfunction

    function void check_result(bit [23:0] data);
      bit [19:0] want;
      if (samples_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sample %h", data);
        return;
      end
      want = samples_due.pop_front();
      if (data[15:0] !== want[15:0] || data[19:16] !== want[19:16]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("sample mismatch: pcm exp %0d got %0d, busy exp %b got %b",
                   $signed(want[15:0]), $signed(data[15:0]), want[19:16], data[19:16]);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [23:0] m_axis_tdata;

  tone_board board = new();
  int  sent;
  int  got;
  bit  calm_out;
  int  idle_cnt;

  sweep_tone_mixer dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Offer one request, maybe after a random gap
  task automatic send(bit [1:0] kind, bit [1:0] wv, int f0, int f1, int ln, int gn,
                      bit calm);
    while (!calm && $urandom_range(0, 99) < 18) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {1'b0, 9'(gn), 16'(ln), 14'(f1), 14'(f0), wv};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(kind, s_axis_tdata);
    sent++;
  endtask

  task automatic send_random_start(bit calm);
    int f0, f1, ln, r;
    r = $urandom_range(0, 99);
    f0 = (r < 10) ? $urandom_range(0, 16383) : $urandom_range(0, 11025);
    f1 = (r < 10) ? $urandom_range(0, 16383) : $urandom_range(0, 11025);
    if (r < 5) ln = 0;
    else if (r < 8) ln = $urandom_range(100, 65535);
    else ln = $urandom_range(1, 40);
    send(KIND_START, 2'($urandom), f0, f1, ln,
         (r > 85) ? $urandom_range(0, 511) : $urandom_range(0, 256), calm);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (board.samples_due.size() != 0) @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    int r;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    repeat (2) @(posedge clk_i);

    // Directed: empty tick, each waveform, extremes, dropped start, zero length, stop
    send(KIND_TICK, 0, 0, 0, 0, 0, 0);
    send(KIND_START, WAVE_SQR, 11025, 0, 65535, 511, 0);
    send(KIND_START, WAVE_TRI, 0, 16383, 3, 256, 0);
    send(KIND_START, WAVE_RND, 440, 440, 1, 256, 0);
    send(KIND_START, WAVE_SIN, 1000, 5000, 10, 0, 0);
    send(KIND_START, WAVE_SIN, 200, 200, 8, 256, 0);
    send(KIND_UNUSED, 2'b11, 16383, 16383, 65535, 511, 0);
    repeat (4) send(KIND_TICK, 0, 0, 0, 0, 0, 0);
    send(KIND_START, WAVE_SIN, 16383, 0, 0, 256, 0);
    send(KIND_START, WAVE_SIN, 3000, 3000, 20, 511, 0);
    repeat (3) send(KIND_TICK, 0, 0, 0, 0, 0, 0);
    send(KIND_STOP, 0, 0, 0, 0, 0, 0);
    send(KIND_TICK, 0, 0, 0, 0, 0, 0);
    for (int w = 0; w < 4; w++) send(KIND_START, 2'(w), 11025, 11025, 6, 256, 0);
    repeat (3) send(KIND_TICK, 0, 0, 0, 0, 0, 0);

    // Random traffic; a stretch with no gaps before ticks and starts, and a drained pause in the middle
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 800) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 68) send(KIND_TICK, 0, 0, 0, 0, 0, i > 500 && i < 750);
      else if (r < 95) send_random_start(i > 500 && i < 750);
      else if (r < 98) send(KIND_STOP, 0, 0, 0, 0, 0, 0);
      else send(KIND_UNUSED, 2'($urandom), $urandom_range(0, 16383),
                $urandom_range(0, 16383), $urandom_range(0, 65535),
                $urandom_range(0, 511), 0);
    end
    wait_drained();
    repeat (400) @(posedge clk_i);
    if (board.mismatches == 0 && board.samples_due.size() == 0) begin
      $display("PASS sweep_tone_mixer");
    end else begin
      $display("FAIL sweep_tone_mixer");
    end
    $finish;
  end

  // Output side: random stalls, one long hold-off, and a stall-free stretch
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (got == 200) begin
        m_axis_tready <= 0;
        repeat (1500) @(posedge clk_i);
        m_axis_tready <= 1;
        wait (got > 200);
      end else begin
        calm_out = got > 400 && got < 700;
        m_axis_tready <= calm_out || $urandom_range(0, 99) >= 18;
      end
    end
  end

  // Sample checker
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      board.check_result(m_axis_tdata);
      got++;
    end
  end

  // Watchdog on cycles without any accepted transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= HOLD_LIMIT) begin
      $display("FAIL sweep_tone_mixer");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

endmodule
